### hdl/template_region_scanner_macros.svh
// ---------------------------------------------------------------------------
// Template region scanner assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef TEMPLATE_REGION_SCANNER_MACROS_SVH
`define TEMPLATE_REGION_SCANNER_MACROS_SVH

// same-cycle implication
`define TRS_ASSERT_NOW(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);

// next-cycle implication
`define TRS_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

### hdl/trs_pkg.sv
// ---------------------------------------------------------------------------
// trs_pkg
// Shared types and character constants of the template region scanner.
// ---------------------------------------------------------------------------
package trs_pkg;

   localparam int TRS_LENGTH_BITS = 16;
   localparam int TRS_CHAR_BITS   = 21;
   localparam int TRS_TOKEN_BITS  = 16;
   localparam int TRS_ADDR_BITS   = 3;
   localparam int TRS_DATA_BITS   = 32;

   typedef logic [TRS_CHAR_BITS-1:0] char_type;

   localparam char_type CH_NUL   = 21'h00;
   localparam char_type CH_NL    = 21'h0A;
   localparam char_type CH_DQ    = 21'h22;
   localparam char_type CH_HASH  = 21'h23;
   localparam char_type CH_PCT   = 21'h25;
   localparam char_type CH_SQ    = 21'h27;
   localparam char_type CH_SLASH = 21'h2F;
   localparam char_type CH_LT    = 21'h3C;
   localparam char_type CH_GT    = 21'h3E;
   localparam char_type CH_BSL   = 21'h5C;
   localparam char_type CH_C     = 21'h63;
   localparam char_type CH_D     = 21'h64;
   localparam char_type CH_E     = 21'h65;
   localparam char_type CH_O     = 21'h6F;
   localparam char_type CH_T     = 21'h74;
   localparam char_type CH_X     = 21'h78;

   typedef enum logic [1:0] {
      MODE_HTML   = 2'd0,
      MODE_PYTHON = 2'd1,
      MODE_TEXT   = 2'd2,
      MODE_DOC    = 2'd3
   } mode_type;

   // match stage codes for html and python modes; text/doc use a plain count
   localparam logic [2:0] STG_IDLE     = 3'd0;
   localparam logic [2:0] STG_LT       = 3'd1;
   localparam logic [2:0] STG_LT_SLASH = 3'd2;
   localparam logic [2:0] STG_HASH     = 3'd3;
   localparam logic [2:0] STG_BSLASH   = 3'd4;
   localparam logic [2:0] STG_PCT      = 3'd1;
   localparam logic [2:0] STG_TEXT_END = 3'd7;
   localparam logic [2:0] STG_DOC_END  = 3'd6;

   localparam logic [1:0] RUN_MAX = 2'd3;

   // register index
   localparam logic [0:0] REG_SCAN_MODE = 1'b0;

   typedef struct packed {
      logic [2:0] match_stage;
      logic       comment_open;
      logic       in_single_string;
      logic       in_double_string;
      logic       in_single_long_string;
      logic       in_double_long_string;
      logic       escape_pending;
      logic [1:0] single_quote_run;
      logic [1:0] double_quote_run;
      logic       seen_any;
      logic       finished;
   } scan_state_type;

   typedef struct packed {
      mode_type mode;
      logic     restart;
   } csr_ctl_type;

   typedef struct packed {
      logic                      done_res;
      logic                      found;
      logic [TRS_TOKEN_BITS-1:0] token_length;
   } result_type;

endpackage

### hdl/trs_csr.sv
// ---------------------------------------------------------------------------
// trs_csr
// APB register file: holds scan_mode and pulses restart on each scan_mode write.
// ---------------------------------------------------------------------------
module trs_csr import trs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [TRS_ADDR_BITS-1:0] csr_paddr,
   input  logic [TRS_DATA_BITS-1:0] csr_pwdata,
   output logic [TRS_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output csr_ctl_type              ctl
);

   mode_type mode_ff, mode_in;
   logic     wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit = csr_psel && csr_penable && csr_pwrite
                   && (csr_paddr[TRS_ADDR_BITS-1] == REG_SCAN_MODE);

   always_comb begin
      mode_in = mode_ff;
      if (wr_hit) begin
         mode_in = mode_type'(csr_pwdata[1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_HTML;
      end else begin
         mode_ff <= mode_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[TRS_ADDR_BITS-1] == REG_SCAN_MODE) begin
         csr_prdata = {{(TRS_DATA_BITS-2){1'b0}}, mode_ff};
      end
   end

   assign ctl.mode    = mode_ff;
   assign ctl.restart = wr_hit;

endmodule

### hdl/trs_step.sv
// ---------------------------------------------------------------------------
// trs_step
// Next-state and result logic for one character of the scan.
// ---------------------------------------------------------------------------
module trs_step import trs_pkg::*; #(
   parameter int LENGTH_BITS = TRS_LENGTH_BITS
) (
   input  mode_type               mode,
   input  char_type               char_code,
   input  scan_state_type         st,
   input  logic [LENGTH_BITS-1:0] consumed,
   input  logic [LENGTH_BITS-1:0] marked,
   output scan_state_type         st_next,
   output logic [LENGTH_BITS-1:0] consumed_next,
   output logic [LENGTH_BITS-1:0] marked_next,
   output result_type             res
);

   function automatic logic [1:0] bump(input logic [1:0] r);
      return (r < RUN_MAX) ? r + 2'd1 : RUN_MAX;
   endfunction

   // expected character of "</%text>" at a stage
   function automatic char_type text_char(input logic [2:0] s);
      char_type ch;
      case (s)
         3'd0:    ch = CH_LT;
         3'd1:    ch = CH_SLASH;
         3'd2:    ch = CH_PCT;
         3'd3:    ch = CH_T;
         3'd4:    ch = CH_E;
         3'd5:    ch = CH_X;
         3'd6:    ch = CH_T;
         default: ch = CH_GT;
      endcase
      return ch;
   endfunction

   // expected character of "</%doc>"; stage 7 never matches
   function automatic char_type doc_char(input logic [2:0] s);
      char_type ch;
      case (s)
         3'd0:    ch = CH_LT;
         3'd1:    ch = CH_SLASH;
         3'd2:    ch = CH_PCT;
         3'd3:    ch = CH_D;
         3'd4:    ch = CH_O;
         3'd5:    ch = CH_C;
         3'd6:    ch = CH_GT;
         default: ch = CH_NUL;
      endcase
      return ch;
   endfunction

   logic [31:0] mark_wide;
   char_type    c;

   assign c = char_code;

   always_comb begin
      scan_state_type         n;
      logic [LENGTH_BITS-1:0] nc;
      logic [LENGTH_BITS-1:0] nm;
      logic                   fresh;
      logic                   term;
      logic                   adv;
      logic [2:0]             adv_stage;
      logic [2:0]             first;
      logic                   closing;

      n         = st;
      nc        = consumed;
      nm        = marked;
      fresh     = 1'b1;
      term      = 1'b0;
      adv       = 1'b0;
      adv_stage = STG_IDLE;
      first     = STG_IDLE;
      closing   = 1'b0;

      if (!st.finished) begin
         if (st.match_stage != STG_IDLE) begin
            fresh = 1'b0;
            unique case (mode)
               MODE_HTML: begin
                  if (st.match_stage == STG_LT) begin
                     if (c == CH_PCT) begin
                        term = 1'b1;
                     end else if (c == CH_SLASH) begin
                        adv       = 1'b1;
                        adv_stage = STG_LT_SLASH;
                     end
                  end else if (st.match_stage == STG_LT_SLASH) begin
                     term = (c == CH_PCT);
                  end else if (st.match_stage == STG_HASH) begin
                     term = (c == CH_HASH);
                  end else if (st.match_stage == STG_BSLASH) begin
                     term = (c == CH_NL);
                  end
               end
               MODE_PYTHON: begin
                  term = (st.match_stage == STG_PCT) && (c == CH_GT);
               end
               MODE_TEXT: begin
                  if (c == text_char(st.match_stage)) begin
                     if (st.match_stage == STG_TEXT_END) begin
                        term = 1'b1;
                     end else begin
                        adv       = 1'b1;
                        adv_stage = st.match_stage + 3'd1;
                     end
                  end
               end
               MODE_DOC: begin
                  if (c == doc_char(st.match_stage)) begin
                     if (st.match_stage == STG_DOC_END) begin
                        term = 1'b1;
                     end else begin
                        adv       = 1'b1;
                        adv_stage = st.match_stage + 3'd1;
                     end
                  end
               end
               default: ;
            endcase

            if (term) begin
               n.match_stage = STG_IDLE;
               n.finished    = 1'b1;
            end else if (adv) begin
               n.match_stage = adv_stage;
               if (nc != '1) nc = nc + 1'b1;
            end else begin
               // broken partial match: re-examine this character
               n.match_stage = STG_IDLE;
               n.seen_any    = 1'b1;
               fresh         = 1'b1;
            end
         end

         if (fresh) begin
            nm = nc;
            if (c == CH_NUL) begin
               n.finished = 1'b1;
            end else begin
               if (nc != '1) nc = nc + 1'b1;
               unique case (mode)
                  MODE_HTML: begin
                     if (c == CH_LT) first = STG_LT;
                     else if (c == CH_HASH) first = STG_HASH;
                     else if (c == CH_BSL) first = STG_BSLASH;
                  end
                  MODE_PYTHON: begin
                     if (n.comment_open) begin
                        n.comment_open = (c != CH_NL);
                     end else if (n.in_single_string) begin
                        closing = (c == CH_SQ) && !n.escape_pending;
                        n.single_quote_run = (n.single_quote_run != 2'd0 && closing)
                                             ? bump(n.single_quote_run) : 2'd0;
                        n.escape_pending   = !n.escape_pending && (c == CH_BSL);
                        n.in_single_string = (c != CH_NL) && !closing;
                     end else if (n.in_double_string) begin
                        closing = (c == CH_DQ) && !n.escape_pending;
                        n.double_quote_run = (n.double_quote_run != 2'd0 && closing)
                                             ? bump(n.double_quote_run) : 2'd0;
                        n.escape_pending   = !n.escape_pending && (c == CH_BSL);
                        n.in_double_string = (c != CH_NL) && !closing;
                     end else if (n.in_single_long_string) begin
                        n.single_quote_run = (c == CH_SQ) ? bump(n.single_quote_run) : 2'd0;
                        if (n.single_quote_run == RUN_MAX) begin
                           n.single_quote_run      = 2'd0;
                           n.in_single_long_string = 1'b0;
                        end
                     end else if (n.in_double_long_string) begin
                        n.double_quote_run = (c == CH_DQ) ? bump(n.double_quote_run) : 2'd0;
                        if (n.double_quote_run == RUN_MAX) begin
                           n.double_quote_run      = 2'd0;
                           n.in_double_long_string = 1'b0;
                        end
                     end else if (c == CH_HASH) begin
                        n.comment_open = 1'b1;
                     end else if (c == CH_SQ) begin
                        if (n.single_quote_run == 2'd2) begin
                           n.in_single_long_string = 1'b1;
                           n.single_quote_run      = 2'd0;
                        end else begin
                           n.single_quote_run = bump(n.single_quote_run);
                           n.in_single_string = 1'b1;
                        end
                     end else if (c == CH_DQ) begin
                        if (n.double_quote_run == 2'd2) begin
                           n.in_double_long_string = 1'b1;
                           n.double_quote_run      = 2'd0;
                        end else begin
                           n.double_quote_run = bump(n.double_quote_run);
                           n.in_double_string = 1'b1;
                        end
                     end else if (c == CH_PCT) begin
                        first = STG_PCT;
                     end else begin
                        n.single_quote_run = 2'd0;
                        n.double_quote_run = 2'd0;
                     end
                  end
                  MODE_TEXT, MODE_DOC: begin
                     if (c == CH_LT) first = STG_LT;
                  end
                  default: ;
               endcase
               n.match_stage = first;
               if (first == STG_IDLE) n.seen_any = 1'b1;
            end
         end
      end

      st_next       = n;
      consumed_next = nc;
      marked_next   = nm;
   end

   assign mark_wide        = 32'(marked_next);
   assign res.done_res     = st_next.finished;
   assign res.found        = st_next.finished && st_next.seen_any;
   assign res.token_length = st_next.finished ? mark_wide[TRS_TOKEN_BITS-1:0] : '0;

endmodule

### hdl/template_region_scanner.sv
// ---------------------------------------------------------------------------
// Template region scanner
// Path: input word register, then trs_step, then result word register.
// Throughput: one character per cycle while rsp_tready is high; the scan
//   state loop needs no extra register, so back-to-back words flow without bubbles.
// Reset: synchronous, active high; clears mode to html, all scan state and
//   both word valid flags. A scan_mode write clears the scan state likewise.
// ---------------------------------------------------------------------------
`include "template_region_scanner_macros.svh"

module template_region_scanner import trs_pkg::*; #(
   parameter int LENGTH_BITS = TRS_LENGTH_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   // input stream
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [23:0]              req_tdata,   // [20:0] char_code, [23:21] zero
   // result stream
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [23:0]              rsp_tdata,   // [0] done_res, [1] found,
                                                 // [17:2] token_length, [23:18] zero
   // register port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [TRS_ADDR_BITS-1:0] csr_paddr,
   input  logic [TRS_DATA_BITS-1:0] csr_pwdata,
   output logic [TRS_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   csr_ctl_type ctl;

   // input word register
   logic     in_valid_ff, in_valid_in;
   char_type in_char_ff, in_char_in;

   // scan state
   scan_state_type         st_ff, st_in, st_next;
   logic [LENGTH_BITS-1:0] cons_ff, cons_in, cons_next;
   logic [LENGTH_BITS-1:0] mark_ff, mark_in, mark_next;

   // result word register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in, res_next;

   logic req_accept;
   logic advance;

   trs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .ctl         (ctl)
   );

   // a character moves from the input register into the scan whenever the
   // result register is free or being emptied this cycle
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
         in_char_in  = req_tdata[TRS_CHAR_BITS-1:0];
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   trs_step #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_step (
      .mode          (ctl.mode),
      .char_code     (in_char_ff),
      .st            (st_ff),
      .consumed      (cons_ff),
      .marked        (mark_ff),
      .st_next       (st_next),
      .consumed_next (cons_next),
      .marked_next   (mark_next),
      .res           (res_next)
   );

   always_comb begin
      st_in   = st_ff;
      cons_in = cons_ff;
      mark_in = mark_ff;
      if (ctl.restart) begin
         // mode write: start a fresh scan
         st_in   = '0;
         cons_in = '0;
         mark_in = '0;
      end else if (advance) begin
         st_in   = st_next;
         cons_in = cons_next;
         mark_in = mark_next;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res_next;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         st_ff        <= '0;
         cons_ff      <= '0;
         mark_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         st_ff        <= st_in;
         cons_ff      <= cons_in;
         mark_ff      <= mark_in;
      end
   end

   // payload only
   always_ff @(posedge clock) begin
      in_char_ff <= in_char_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_ff.token_length, rsp_ff.found, rsp_ff.done_res};

   // ---- checks ----
   `TRS_ASSERT_NOW(a_found_needs_done, clock, reset, rsp_tvalid && rsp_ff.found, rsp_ff.done_res, "found without done")
   `TRS_ASSERT_NOW(a_len_zero_open, clock, reset, rsp_tvalid && !rsp_ff.done_res, rsp_ff.token_length == '0, "length before done")
   `TRS_ASSERT_NEXT(a_finished_sticky, clock, reset, st_ff.finished && !ctl.restart, st_ff.finished, "finished dropped")
   `TRS_ASSERT_NOW(a_no_match_when_done, clock, reset, st_ff.finished, st_ff.match_stage == STG_IDLE, "match after done")

endmodule

### test/template_region_scanner_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Template region scanner testbench
// Streams characters into the scanner under all four region modes and checks
// every result word against a cycle-free predictor kept in step at each
// accepted word, or against the word pinned for it in the directed table.
// Directed rows first, then random mode-specific fragments, a calm idle-free tail.
// ---------------------------------------------------------------------------
module template_region_scanner_tb;
   import trs_pkg::*;

   localparam int RUN_LIMIT       = 4_000_000;
   localparam int RANDOM_ITEMS    = 1250;    // characters sent before the tail
   localparam int TAIL_ITEMS      = 150;     // characters in the calm tail
   localparam int HOLD_AFTER      = 300;     // result words before the long hold-off
   localparam int HOLD_CYCLES     = 400;
   localparam logic [TRS_ADDR_BITS-1:0] MODE_ADDR = TRS_ADDR_BITS'(4 * REG_SCAN_MODE);

   typedef enum logic [1:0] {MATCH_BREAK, MATCH_STEP, MATCH_HIT} match_type;
   typedef enum logic {ROW_MODE, ROW_CHAR} row_kind_type;

   // one line of the directed table; word is used only where pinned is set
   typedef struct packed {
      row_kind_type kind;
      logic         pinned;
      char_type     value;
      result_type   word;
   } plan_row_type;

   typedef struct packed {
      logic       pinned;
      result_type word;
   } typed_word_type;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [23:0]              req_tdata;    // [20:0] char_code, [23:21] zero
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [23:0]              rsp_tdata;    // [0] done_res, [1] found, [17:2] token_length
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [TRS_ADDR_BITS-1:0] csr_paddr;
   logic [TRS_DATA_BITS-1:0] csr_pwdata;
   logic [TRS_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   // predictor state
   mode_type                  scan_mode_q;
   scan_state_type            scan_st;
   logic [TRS_TOKEN_BITS-1:0] consumed_len;
   logic [TRS_TOKEN_BITS-1:0] marked_len;

   result_type     expected_words [$];
   typed_word_type pinned_words [$];
   int             errors      = 0;
   int             clock_ticks = 0;
   int             words_seen  = 0;
   int             live_items  = 0;   // characters accepted so far
   bit             pace_on     = 1'b1;
   bit             hold_done   = 1'b0;

   template_region_scanner u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) clock_ticks <= clock_ticks + 1;

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // quote runs stick at three
   function automatic logic [1:0] run_up(logic [1:0] r);
      return (r < RUN_MAX) ? r + 2'd1 : RUN_MAX;
   endfunction

   function automatic void scan_clear();
      scan_st      = '0;
      consumed_len = '0;
      marked_len   = '0;
   endfunction

   // consumed count saturates rather than wrapping
   function automatic void tally();
      if (consumed_len != '1) consumed_len = consumed_len + 1'b1;
   endfunction

   // Python block: strings and comments swallow everything, so only a '%'
   // outside them can open the close tag.
   function automatic logic [2:0] python_open(char_type c);
      logic closing;
      if (scan_st.comment_open) begin
         scan_st.comment_open = (c != CH_NL);
         return STG_IDLE;
      end
      if (scan_st.in_single_string) begin
         closing = (c == CH_SQ) && !scan_st.escape_pending;
         scan_st.single_quote_run = (scan_st.single_quote_run != 2'd0 && closing) ?
                                    run_up(scan_st.single_quote_run) : 2'd0;
         scan_st.escape_pending   = !scan_st.escape_pending && c == CH_BSL;
         scan_st.in_single_string = (c != CH_NL) && !closing;
         return STG_IDLE;
      end
      if (scan_st.in_double_string) begin
         closing = (c == CH_DQ) && !scan_st.escape_pending;
         scan_st.double_quote_run = (scan_st.double_quote_run != 2'd0 && closing) ?
                                    run_up(scan_st.double_quote_run) : 2'd0;
         scan_st.escape_pending   = !scan_st.escape_pending && c == CH_BSL;
         scan_st.in_double_string = (c != CH_NL) && !closing;
         return STG_IDLE;
      end
      if (scan_st.in_single_long_string) begin
         scan_st.single_quote_run = (c == CH_SQ) ? run_up(scan_st.single_quote_run) : 2'd0;
         if (scan_st.single_quote_run == RUN_MAX) begin
            scan_st.single_quote_run      = 2'd0;
            scan_st.in_single_long_string = 1'b0;
         end
         return STG_IDLE;
      end
      if (scan_st.in_double_long_string) begin
         scan_st.double_quote_run = (c == CH_DQ) ? run_up(scan_st.double_quote_run) : 2'd0;
         if (scan_st.double_quote_run == RUN_MAX) begin
            scan_st.double_quote_run      = 2'd0;
            scan_st.in_double_long_string = 1'b0;
         end
         return STG_IDLE;
      end
      if (c == CH_HASH) begin
         scan_st.comment_open = 1'b1;
         return STG_IDLE;
      end
      // third quote of a run opens a triple-quoted string
      if (c == CH_SQ) begin
         if (scan_st.single_quote_run == 2'd2) begin
            scan_st.in_single_long_string = 1'b1;
            scan_st.single_quote_run      = 2'd0;
         end else begin
            scan_st.single_quote_run = run_up(scan_st.single_quote_run);
            scan_st.in_single_string = 1'b1;
         end
         return STG_IDLE;
      end
      if (c == CH_DQ) begin
         if (scan_st.double_quote_run == 2'd2) begin
            scan_st.in_double_long_string = 1'b1;
            scan_st.double_quote_run      = 2'd0;
         end else begin
            scan_st.double_quote_run = run_up(scan_st.double_quote_run);
            scan_st.in_double_string = 1'b1;
         end
         return STG_IDLE;
      end
      if (c == CH_PCT) return STG_PCT;
      scan_st.single_quote_run = 2'd0;
      scan_st.double_quote_run = 2'd0;
      return STG_IDLE;
   endfunction

   function automatic logic [2:0] element_start(char_type c);
      case (scan_mode_q)
         MODE_HTML: begin
            if (c == CH_LT) return STG_LT;
            if (c == CH_HASH) return STG_HASH;
            if (c == CH_BSL) return STG_BSLASH;
            return STG_IDLE;
         end
         MODE_PYTHON: return python_open(c);
         default:     return (c == CH_LT) ? STG_LT : STG_IDLE;
      endcase
   endfunction

   // character expected at a given position of the text / doc close tag
   function automatic char_type closer_at(mode_type m, logic [2:0] i);
      case (i)
         3'd0:    return CH_LT;
         3'd1:    return CH_SLASH;
         3'd2:    return CH_PCT;
         3'd3:    return (m == MODE_TEXT) ? CH_T : CH_D;
         3'd4:    return (m == MODE_TEXT) ? CH_E : CH_O;
         3'd5:    return (m == MODE_TEXT) ? CH_X : CH_C;
         3'd6:    return (m == MODE_TEXT) ? CH_T : CH_GT;
         default: return CH_GT;
      endcase
   endfunction

   function automatic match_type match_more(char_type c);
      logic [2:0] s;
      logic [2:0] last;
      s = scan_st.match_stage;
      case (scan_mode_q)
         MODE_HTML: begin
            if (s == STG_LT) begin
               if (c == CH_PCT) return MATCH_HIT;
               if (c == CH_SLASH) begin
                  scan_st.match_stage = STG_LT_SLASH;
                  return MATCH_STEP;
               end
               return MATCH_BREAK;
            end
            if (s == STG_LT_SLASH) return (c == CH_PCT) ? MATCH_HIT : MATCH_BREAK;
            if (s == STG_HASH) return (c == CH_HASH) ? MATCH_HIT : MATCH_BREAK;
            if (s == STG_BSLASH) return (c == CH_NL) ? MATCH_HIT : MATCH_BREAK;
            return MATCH_BREAK;
         end
         MODE_PYTHON: return (s == STG_PCT && c == CH_GT) ? MATCH_HIT : MATCH_BREAK;
         default: begin
            last = (scan_mode_q == MODE_TEXT) ? STG_TEXT_END : STG_DOC_END;
            if (s > last || c != closer_at(scan_mode_q, s)) return MATCH_BREAK;
            if (s == last) return MATCH_HIT;
            scan_st.match_stage = s + 3'd1;
            return MATCH_STEP;
         end
      endcase
   endfunction

   // advance the scan by one character and form the result word it yields
   function automatic result_type scan_char(char_type c);
      logic       fresh;
      match_type  m;
      logic [2:0] stage;
      result_type res;
      if (!scan_st.finished) begin
         fresh = 1'b1;
         if (scan_st.match_stage != STG_IDLE) begin
            m     = match_more(c);
            fresh = 1'b0;
            if (m == MATCH_HIT) begin
               scan_st.match_stage = STG_IDLE;
               scan_st.finished    = 1'b1;
            end else if (m == MATCH_STEP) begin
               tally();
            end else begin
               // broken partial match: this character starts afresh
               scan_st.match_stage = STG_IDLE;
               scan_st.seen_any    = 1'b1;
               fresh               = 1'b1;
            end
         end
         if (fresh) begin
            marked_len = consumed_len;
            if (c == CH_NUL) begin
               scan_st.finished = 1'b1;
            end else begin
               tally();
               stage               = element_start(c);
               scan_st.match_stage = stage;
               if (stage == STG_IDLE) scan_st.seen_any = 1'b1;
            end
         end
      end
      res.done_res     = scan_st.finished;
      res.found        = scan_st.finished && scan_st.seen_any;
      res.token_length = scan_st.finished ? marked_len : '0;
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Scoreboard: follows register writes and accepted words at each edge
   // ------------------------------------------------------------------------

   task automatic note_mismatch(string what);
      $display("mismatch at cycle %0d: %s", clock_ticks, what);
      errors++;
   endtask

   always @(posedge clock) begin : scoreboard
      result_type     got;
      result_type     want;
      typed_word_type tw;
      if (reset) begin
         scan_mode_q = MODE_HTML;
         scan_clear();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == MODE_ADDR) begin
            scan_mode_q = mode_type'(csr_pwdata[1:0]);
            scan_clear();
         end
         if (req_tvalid && req_tready) begin
            live_items++;
            want = scan_char(req_tdata[TRS_CHAR_BITS-1:0]);
            tw   = pinned_words.pop_front();
            // a typed-in word from the directed table overrides the predictor
            expected_words.push_back(tw.pinned ? tw.word : want);
         end
         if (rsp_tvalid && rsp_tready) begin
            words_seen++;
            got = {rsp_tdata[0], rsp_tdata[1], rsp_tdata[17:2]};
            if (expected_words.size() == 0) begin
               note_mismatch($sformatf("word %0d arrived with nothing expected", words_seen));
            end else begin
               want = expected_words.pop_front();
               if (got.done_res != want.done_res)
                  note_mismatch($sformatf("word %0d done_res %0b, expected %0b",
                                          words_seen, got.done_res, want.done_res));
               if (got.found != want.found)
                  note_mismatch($sformatf("word %0d found %0b, expected %0b",
                                          words_seen, got.found, want.found));
               if (got.token_length != want.token_length)
                  note_mismatch($sformatf("word %0d token_length %0d, expected %0d",
                                          words_seen, got.token_length, want.token_length));
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result side: short random stalls, plus one long hold-off so the
   // pipeline backs up and the input stalls
   // ------------------------------------------------------------------------
   initial begin : result_taker
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && words_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (pace_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   // ------------------------------------------------------------------------
   // Input side
   // ------------------------------------------------------------------------

   task automatic send_char(char_type c, logic pinned = 1'b0, result_type word = '0);
      int gap;
      if (pace_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pinned_words.push_back({pinned, word});
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, c};
      do @(posedge clock); while (!req_tready);
   endtask

   // mode writes only once the block has drained
   task automatic write_mode(mode_type m);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= MODE_ADDR;
      // upper bits are junk; only the low two bits select the mode
      csr_pwdata  <= (32'($urandom()) & ~32'h3) | 32'(m);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic plan_row_type step_row(row_kind_type k, char_type v, logic p = 1'b0,
                                             logic d = 1'b0, logic f = 1'b0,
                                             logic [TRS_TOKEN_BITS-1:0] n = '0);
      return {k, p, v, d, f, n};
   endfunction

   // fragments lean towards the characters each mode cares about
   function automatic string fragment(mode_type m);
      case (m)
         MODE_HTML:
            case ($urandom_range(0, 15))
               0:       return "<%";
               1:       return "</%";
               2:       return "##";
               3:       return "\\\n";
               4:       return "<";
               5:       return "</";
               6:       return "#";
               7:       return "\\";
               8:       return "<b";
               9:       return "</p";
               10:      return "#a";
               11:      return "\\n";
               12:      return "%/";
               13:      return "\n";
               14:      return "<<%";
               default: return "text";
            endcase
         MODE_PYTHON:
            case ($urandom_range(0, 21))
               0:       return "#note %>\n";
               1:       return "'x'";
               2:       return "\"y\"";
               3:       return "'%>'";
               4:       return "\"%>\"";
               5:       return "'''a'\n%>'''";
               6:       return "\"\"\"b\"\n%>\"\"\"";
               7:       return "'\\''";
               8:       return "\"\\\"\"";
               9:       return "'\\\\'";
               10:      return "''";
               11:      return "\"\"";
               12:      return "'a\n";
               13:      return "\"b\n";
               14:      return "%>";
               15:      return "%";
               16:      return ">";
               17:      return "x = 1";
               18:      return "'''";
               19:      return "\"\"\"";
               20:      return "\\";
               default: return "\n";
            endcase
         MODE_TEXT:
            case ($urandom_range(0, 10))
               0:       return "</%text>";
               1:       return "</%tex";
               2:       return "</%t";
               3:       return "</%";
               4:       return "</";
               5:       return "<";
               6:       return "<</%text>";
               7:       return "</%doc>";
               8:       return "%>";
               9:       return "\n";
               default: return "abc";
            endcase
         default:
            case ($urandom_range(0, 10))
               0:       return "</%doc>";
               1:       return "</%do";
               2:       return "</%d";
               3:       return "</%";
               4:       return "</";
               5:       return "<";
               6:       return "<</%doc>";
               7:       return "</%text>";
               8:       return "##";
               9:       return "\n";
               default: return "doc";
            endcase
      endcase
   endfunction

   initial begin : stimulus
      plan_row_type plan [$];
      char_type     script [$];
      string        frag;
      int           k;
      int           pieces;
      int           stop_at;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table; after reset the mode is html
      // input end straight away, then a character that must be ignored
      plan.push_back(step_row(ROW_CHAR, CH_NUL,  1'b1, 1'b1, 1'b0, 16'd0));
      plan.push_back(step_row(ROW_CHAR, CH_X,    1'b1, 1'b1, 1'b0, 16'd0));
      // widest code is an ordinary character; "</%" closes after two
      plan.push_back(step_row(ROW_MODE, char_type'(MODE_HTML)));
      plan.push_back(step_row(ROW_CHAR, 21'h1FFFFF, 1'b1));
      plan.push_back(step_row(ROW_CHAR, CH_X,       1'b1));
      plan.push_back(step_row(ROW_CHAR, CH_LT,      1'b1));
      plan.push_back(step_row(ROW_CHAR, CH_SLASH,   1'b1));
      plan.push_back(step_row(ROW_CHAR, CH_PCT,     1'b1, 1'b1, 1'b1, 16'd2));
      // close tag at the very start: empty token
      plan.push_back(step_row(ROW_MODE, char_type'(MODE_HTML)));
      plan.push_back(step_row(ROW_CHAR, CH_LT,  1'b1));
      plan.push_back(step_row(ROW_CHAR, CH_PCT, 1'b1, 1'b1, 1'b0, 16'd0));
      // broken "##", then backslash-newline
      plan.push_back(step_row(ROW_MODE, char_type'(MODE_HTML)));
      plan.push_back(step_row(ROW_CHAR, CH_HASH));
      plan.push_back(step_row(ROW_CHAR, CH_X));
      plan.push_back(step_row(ROW_CHAR, CH_BSL));
      plan.push_back(step_row(ROW_CHAR, CH_NL,  1'b1, 1'b1, 1'b1, 16'd2));
      // input end inside a partial match counts the partial character
      plan.push_back(step_row(ROW_MODE, char_type'(MODE_HTML)));
      plan.push_back(step_row(ROW_CHAR, CH_LT));
      plan.push_back(step_row(ROW_CHAR, CH_NUL, 1'b1, 1'b1, 1'b1, 16'd1));
      // python comment hides nothing past its newline
      plan.push_back(step_row(ROW_MODE, char_type'(MODE_PYTHON)));
      plan.push_back(step_row(ROW_CHAR, CH_HASH));
      plan.push_back(step_row(ROW_CHAR, CH_NL));
      plan.push_back(step_row(ROW_CHAR, CH_PCT));
      plan.push_back(step_row(ROW_CHAR, CH_GT,  1'b1, 1'b1, 1'b1, 16'd2));
      // doc close tag at the start
      plan.push_back(step_row(ROW_MODE, char_type'(MODE_DOC)));
      plan.push_back(step_row(ROW_CHAR, CH_LT));
      plan.push_back(step_row(ROW_CHAR, CH_SLASH));
      plan.push_back(step_row(ROW_CHAR, CH_PCT));
      plan.push_back(step_row(ROW_CHAR, CH_D));
      plan.push_back(step_row(ROW_CHAR, CH_O));
      plan.push_back(step_row(ROW_CHAR, CH_C));
      plan.push_back(step_row(ROW_CHAR, CH_GT,  1'b1, 1'b1, 1'b0, 16'd0));

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_MODE)
            write_mode(mode_type'(plan[i].value[1:0]));
         else
            send_char(plan[i].value, plan[i].pinned, plan[i].word);
      end

      // random scans: one mode write, a run of fragments, an optional ending
      stop_at = RANDOM_ITEMS;
      for (int phase = 0; phase < 2; phase++) begin
         while (live_items < stop_at) begin
            write_mode(mode_type'($urandom_range(0, 3)));
            script.delete();
            pieces = $urandom_range(1, 8);
            repeat (pieces) begin
               if ($urandom_range(0, 9) == 0)
                  script.push_back(char_type'($urandom_range(1, 21'h1FFFFF)));
               frag = fragment(scan_mode_q);
               for (k = 0; k < frag.len(); k++) script.push_back({13'd0, frag[k]});
            end
            case ($urandom_range(0, 2))
               0:       script.push_back(CH_NUL);
               1:       script.push_back(char_type'($urandom_range(0, 21'h1FFFFF)));
               default: ;
            endcase
            foreach (script[i]) send_char(script[i]);
         end
         if (phase == 0) begin
            // calm tail: no idling on either side
            pace_on = 1'b0;
            stop_at = live_items + TAIL_ITEMS;
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0 && expected_words.size() == 0)
         $display("template_region_scanner_tb: PASS");
      else
         $display("template_region_scanner_tb: FAIL");
      $finish;
   end

   // run limit
   initial begin : watchdog
      while (clock_ticks < RUN_LIMIT) @(posedge clock);
      $display("template_region_scanner_tb: FAIL");
      $finish;
   end

endmodule

### files.f
+incdir+hdl
hdl/trs_pkg.sv
hdl/trs_csr.sv
hdl/trs_step.sv
hdl/template_region_scanner.sv
test/template_region_scanner_tb.sv
